// ===== design/krus_pkg.sv =====
// ----------------------------------------------------------------------------
// krus_pkg
// Shared constants for the k-mer rotation universal set test.
// ----------------------------------------------------------------------------
package krus_pkg;

  localparam int unsigned KMER_W   = 64;
  localparam int unsigned KLEN_W   = 6;
  localparam int unsigned WMOD_W   = 7;
  localparam int unsigned VAL_W    = 5;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MODULUS = 4'd1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd16;
  localparam logic [WMOD_W-1:0] WMOD_RESET = 7'd8;

endpackage

// ===== design/krus_cell.sv =====
// ----------------------------------------------------------------------------
// krus_cell
// One rotation step: rotates the word right by one base and keeps the
// first strictly smallest rotation seen so far with its index.
// ----------------------------------------------------------------------------
module krus_cell #(
  parameter int unsigned STEP   = 1,
  parameter int unsigned WORD_W = 62,
  parameter int unsigned NW     = 5
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NW-1:0]     n_i,
  input  logic [WORD_W-1:0] cur_i,
  input  logic [WORD_W-1:0] best_i,
  input  logic [NW-1:0]     idx_i,
  output logic [WORD_W-1:0] cur_o,
  output logic [WORD_W-1:0] best_o,
  output logic [NW-1:0]     idx_o
);

  localparam logic [NW-1:0] STEP_C = NW'(STEP);

  logic [NW:0]       top_sh;
  logic [WORD_W-1:0] rot;
  logic              active;
  logic [WORD_W-1:0] cur_d, cur_q;
  logic [WORD_W-1:0] best_d, best_q;
  logic [NW-1:0]     idx_d, idx_q;

  assign top_sh = {n_i - 1'b1, 1'b0};
  assign rot    = (cur_i >> 2) | (WORD_W'(cur_i[1:0]) << top_sh);
  assign active = STEP_C < n_i;

  always_comb begin
    cur_d  = cur_i;
    best_d = best_i;
    idx_d  = idx_i;
    if (active) begin
      cur_d = rot;
      if (rot < best_i) begin
        best_d = rot;
        idx_d  = STEP_C;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cur_q  <= cur_d;
      best_q <= best_d;
      idx_q  <= idx_d;
    end
  end

  assign cur_o  = cur_q;
  assign best_o = best_q;
  assign idx_o  = idx_q;

endmodule

// ===== design/krus_mod.sv =====
// ----------------------------------------------------------------------------
// krus_mod
// Small remainder unit: rotation index modulo w by restoring subtraction.
// ----------------------------------------------------------------------------
module krus_mod import krus_pkg::*; #(
  parameter int unsigned NW = 5
) (
  input  logic [NW-1:0]     val_i,
  input  logic [WMOD_W-1:0] mod_i,
  output logic [VAL_W-1:0]  rem_o
);

  localparam int unsigned RW = WMOD_W + NW;

  logic [RW-1:0] r;
  logic [RW-1:0] dv;

  always_comb begin
    r  = RW'(val_i);
    dv = '0;
    for (int s = NW - 1; s >= 0; s--) begin
      dv = RW'(mod_i) << s;
      if (dv <= r) begin
        r = r - dv;
      end
    end
  end

  assign rem_o = VAL_W'(r[NW-1:0]);

endmodule

// ===== design/kmer_rotation_universal_set_test_top.sv =====
// ----------------------------------------------------------------------------
// kmer_rotation_universal_set_test_top
// Universal set membership test for k-mers via minimal rotation index.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+----------------------------------
//   in      | in  | in_valid_i/in_stall_o  | kmer_i
//   out     | out | out_valid_o/out_stall_i| selected_o prefix_value_o
//           |     |                        | suffix_value_o
//   cfg     | in  | cfg_we_i               | cfg_idx_i cfg_wdata_i
//
// One beat per cycle unless the output stalls. A beat passes the MAX_BASES-2
// registered rotation cells, then the output register holding the remainder.
// Reset puts kmer_length at 16, window_modulus at 8 and empties the pipe.
// A stalled output beat freezes the whole cell chain and stalls the input.
// ----------------------------------------------------------------------------
module kmer_rotation_universal_set_test_top import krus_pkg::*; #(
  parameter int unsigned MAX_BASES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KMER_W-1:0]     kmer_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  selected_o,
  output logic [VAL_W-1:0]      prefix_value_o,
  output logic [VAL_W-1:0]      suffix_value_o
);

  localparam int unsigned WORD_W = 2 * (MAX_BASES - 1);
  localparam int unsigned NW     = $clog2(MAX_BASES);
  localparam int unsigned NCELL  = (MAX_BASES > 2) ? MAX_BASES - 2 : 1;

  logic [KLEN_W-1:0] klen_q;
  logic [WMOD_W-1:0] wmod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_RESET;
      wmod_q <= WMOD_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_KMER_LENGTH) begin
        klen_q <= cfg_wdata_i[KLEN_W-1:0];
      end else if (cfg_idx_i == REG_WINDOW_MODULUS) begin
        wmod_q <= cfg_wdata_i[WMOD_W-1:0];
      end
    end
  end

  logic [KLEN_W-1:0] k_eff;
  logic [NW-1:0]     n;
  logic [WMOD_W-1:0] w_eff;

  always_comb begin
    k_eff = klen_q;
    if (klen_q < KLEN_W'(2)) begin
      k_eff = KLEN_W'(2);
    end else if (klen_q > KLEN_W'(MAX_BASES)) begin
      k_eff = KLEN_W'(MAX_BASES);
    end
  end

  assign n     = NW'(k_eff - 1'b1);
  assign w_eff = (wmod_q == '0) ? WMOD_W'(1) : wmod_q;

  logic              adv;
  logic              out_valid_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  logic [WORD_W-1:0] mask;

  for (genvar j = 0; j < WORD_W; j++) begin : g_mask
    assign mask[j] = NW'(j / 2) < n;
  end

  logic [WORD_W-1:0] pcur  [NCELL+1];
  logic [WORD_W-1:0] pbest [NCELL+1];
  logic [NW-1:0]     pidx  [NCELL+1];
  logic [WORD_W-1:0] scur  [NCELL+1];
  logic [WORD_W-1:0] sbest [NCELL+1];
  logic [NW-1:0]     sidx  [NCELL+1];
  logic              vld   [NCELL+1];

  assign pcur[0]  = kmer_i[WORD_W+1:2] & mask;
  assign pbest[0] = kmer_i[WORD_W+1:2] & mask;
  assign pidx[0]  = '0;
  assign scur[0]  = kmer_i[WORD_W-1:0] & mask;
  assign sbest[0] = kmer_i[WORD_W-1:0] & mask;
  assign sidx[0]  = '0;
  assign vld[0]   = in_valid_i;

  for (genvar c = 1; c <= NCELL; c++) begin : g_cell
    logic vld_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (adv) begin
        vld_q <= vld[c-1];
      end
    end

    assign vld[c] = vld_q;

    krus_cell #(.STEP(c), .WORD_W(WORD_W), .NW(NW)) u_pre (
      .clk_i  (clk_i),
      .en_i   (adv),
      .n_i    (n),
      .cur_i  (pcur[c-1]),
      .best_i (pbest[c-1]),
      .idx_i  (pidx[c-1]),
      .cur_o  (pcur[c]),
      .best_o (pbest[c]),
      .idx_o  (pidx[c])
    );

    krus_cell #(.STEP(c), .WORD_W(WORD_W), .NW(NW)) u_suf (
      .clk_i  (clk_i),
      .en_i   (adv),
      .n_i    (n),
      .cur_i  (scur[c-1]),
      .best_i (sbest[c-1]),
      .idx_i  (sidx[c-1]),
      .cur_o  (scur[c]),
      .best_o (sbest[c]),
      .idx_o  (sidx[c])
    );
  end

  logic [VAL_W-1:0] pv, sv;

  krus_mod #(.NW(NW)) u_pmod (
    .val_i (pidx[NCELL]),
    .mod_i (w_eff),
    .rem_o (pv)
  );

  krus_mod #(.NW(NW)) u_smod (
    .val_i (sidx[NCELL]),
    .mod_i (w_eff),
    .rem_o (sv)
  );

  logic             sel_q;
  logic [VAL_W-1:0] pv_q, sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_q <= (sv <= pv);
      pv_q  <= pv;
      sv_q  <= sv;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign selected_o     = sel_q;
  assign prefix_value_o = pv_q;
  assign suffix_value_o = sv_q;

endmodule
